### src/rbs_pkg.sv
package rbs_pkg;

    typedef enum logic [1:0] {
        KIND_A,
        KIND_B,
        KIND_OTHER
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [62:0]        price;
        logic signed [63:0] tick_time;
    } qitem_t;

    // ring depth; a power of two so the window means are plain shifts
    localparam int WINDOW_LEN = 256;

    localparam logic CFG_THRESH = 1'b0;
    localparam logic CFG_MINVAR = 1'b1;

    localparam logic [30:0] THRESH_RESET = 31'd838861;
    localparam logic [31:0] MINVAR_RESET = 32'd281;
    localparam logic [27:0] LN2_Q28      = 28'd186065279;
    localparam logic signed [33:0] ONE_Q24 = 34'sd16777216;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [31:0] S32_MAX = {1'b0, {31{1'b1}}};
    localparam logic signed [31:0] S32_MIN = {1'b1, {31{1'b0}}};

    function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub64(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [39:0] clamp40(logic signed [40:0] v);
        if (v[40] != v[39])
            return v[40] ? {1'b1, {39{1'b0}}} : {1'b0, {39{1'b1}}};
        return v[39:0];
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'(S32_MAX))
            return S32_MAX;
        if (v < 64'(S32_MIN))
            return S32_MIN;
        return v[31:0];
    endfunction

endpackage

### src/rbs_ram.sv
module rbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### src/rbs_front.sv
module rbs_front
    import rbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // price[62:0], tick_time[126:63], pad
    input  logic [1:0]   s_axis_tuser,  // symbol[1:0]
    output logic         q_valid,
    output qitem_t       q_item,
    input  logic         q_pop
);

    qitem_t     ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    qitem_t     in_item;

    always_comb
    begin
        unique case (s_axis_tuser)
            2'd0:    in_item.kind = KIND_A;
            2'd1:    in_item.kind = KIND_B;
            default: in_item.kind = KIND_OTHER;
        endcase
        in_item.price     = s_axis_tdata[62:0];
        in_item.tick_time = s_axis_tdata[126:63];
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != 2'd0);
    assign q_item        = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                ent_reg[wr_ptr_reg] <= in_item;
                wr_ptr_reg          <= ~wr_ptr_reg;
            end
            if (q_pop && q_valid)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

endmodule

### src/rbs_log.sv
module rbs_log
    import rbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [62:0] x,
    output logic        done,
    output logic [33:0] result   // {exponent, 28-bit fraction}
);

    localparam int LAST_STEP = 34;

    logic [5:0]  step_reg;
    logic        run_reg;
    logic        done_reg;
    logic [62:0] x_reg;
    logic [5:0]  e_reg;
    logic [31:0] y_reg;
    logic [27:0] frac_reg;
    logic [5:0]  sh;
    logic        top_zero;
    logic [63:0] sq;

    assign sh       = 6'd32 >> step_reg[2:0];
    assign top_zero = ((x_reg >> (7'd63 - {1'b0, sh})) == 63'd0);
    assign sq       = y_reg * y_reg;
    assign done     = done_reg;
    assign result   = {e_reg, frac_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 6'd0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            x_reg    <= 63'd0;
            e_reg    <= 6'd0;
            y_reg    <= 32'd0;
            frac_reg <= 28'd0;
        end
        else if (start)
        begin
            x_reg    <= x;
            e_reg    <= 6'd62;
            frac_reg <= 28'd0;
            step_reg <= 6'd0;
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            // normalize in six halving steps, then square once per fraction bit
            if (step_reg < 6'd6)
            begin
                if (top_zero)
                begin
                    x_reg <= x_reg << sh;
                    e_reg <= e_reg - sh;
                end
            end
            else if (step_reg == 6'd6)
                y_reg <= x_reg[62:31];
            else
            begin
                frac_reg <= {frac_reg[26:0], sq[63]};
                y_reg    <= sq[63] ? sq[63:32] : sq[62:31];
            end
            if (step_reg == 6'(LAST_STEP))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
            step_reg <= step_reg + 6'd1;
        end
    end

endmodule

### src/rbs_back.sv
module rbs_back
    import rbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         q_valid,
    input  qitem_t       q_item,
    output logic         q_pop,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata
);

    localparam int AW = $clog2(WINDOW_LEN);
    localparam int CW = $clog2(WINDOW_LEN + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_LOG, S_RMUL, S_RET, S_P1, S_P2, S_P3, S_P4, S_EVAL,
        S_MEAN, S_MA, S_MB, S_VAR, S_CHK, S_BDIV, S_DEC, S_OUT
    } state_t;

    state_t state_reg;

    logic [30:0] thr_reg;
    logic [31:0] minv_reg;

    kind_t              kind_reg;
    logic [62:0]        price_reg;
    logic signed [63:0] time_reg;
    logic [62:0]        last_a_reg, last_b_reg;
    logic [AW-1:0]      head_a_reg, head_b_reg;
    logic [CW-1:0]      cnt_a_reg, cnt_b_reg, fill_reg;
    logic signed [39:0] sum_a_reg, sum_b_reg;
    logic signed [63:0] sq_a_reg, sq_b_reg, cross_reg;

    logic               neg_reg;
    logic [33:0]        mag_reg;
    logic [61:0]        lnp_reg;
    logic signed [31:0] ret_reg;
    logic signed [63:0] mprod_reg;

    logic [63:0]        lane_dq_reg  [4];
    logic               lane_neg_reg [4];
    logic [5:0]         step_reg;

    logic signed [31:0] ma_reg, mb_reg;
    logic signed [63:0] cov_reg, var_reg;
    logic [69:0]        r_reg, d_reg;
    logic [30:0]        q_reg;
    logic               bsat_reg;
    logic signed [31:0] beta_reg;

    logic               out_valid_reg;
    logic signed [63:0] out_time_reg;
    logic signed [31:0] out_beta_reg;
    logic               out_dir_reg;

    // log units and ring buffers
    logic        log_start;
    logic [62:0] last_own;
    logic        done_p, done_l;
    logic [33:0] log_p, log_l;

    logic          is_b;
    logic [AW-1:0] head_own;
    logic [31:0]   rdata_a, rdata_b;
    logic          we_a, we_b;

    logic signed [31:0] old_v, peer_v, mul_x, mul_y;
    logic signed [63:0] mul_p;
    logic signed [34:0] ldiff;
    logic [62:0]        rnd;
    logic signed [39:0] sum_own;
    logic signed [63:0] sq_own;
    logic signed [63:0] lane_val [4];
    logic signed [63:0] lane_q   [4];
    logic [63:0]        cmag;
    logic [69:0]        r_sub;
    logic               r_ge;
    logic signed [33:0] dev;
    logic [33:0]        dev_mag;
    logic               out_load;
    integer             k;

    assign is_b      = (kind_reg == KIND_B);
    assign head_own  = is_b ? head_b_reg : head_a_reg;
    assign last_own  = (q_item.kind == KIND_B) ? last_b_reg : last_a_reg;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign log_start = q_pop && (q_item.kind != KIND_OTHER);
    assign we_a      = (state_reg == S_P2) && (kind_reg == KIND_A);
    assign we_b      = (state_reg == S_P2) && is_b;

    rbs_log u_log_p (
        .clk(clk), .rst_n(rst_n), .start(log_start), .x(q_item.price),
        .done(done_p), .result(log_p)
    );

    rbs_log u_log_l (
        .clk(clk), .rst_n(rst_n), .start(log_start), .x(last_own),
        .done(done_l), .result(log_l)
    );

    rbs_ram #(.WIDTH(32), .DEPTH(WINDOW_LEN)) u_ram_a (
        .clk(clk), .we(we_a), .waddr(head_own), .wdata(ret_reg),
        .raddr(head_own), .rdata(rdata_a)
    );

    rbs_ram #(.WIDTH(32), .DEPTH(WINDOW_LEN)) u_ram_b (
        .clk(clk), .we(we_b), .waddr(head_own), .wdata(ret_reg),
        .raddr(head_own), .rdata(rdata_b)
    );

    // entries past an asset's push count were never written: read as zero
    always_comb
    begin
        if (is_b)
        begin
            old_v  = (cnt_b_reg > CW'(head_own)) ? rdata_b : 32'sd0;
            peer_v = (cnt_a_reg > CW'(head_own)) ? rdata_a : 32'sd0;
        end
        else
        begin
            old_v  = (cnt_a_reg > CW'(head_own)) ? rdata_a : 32'sd0;
            peer_v = (cnt_b_reg > CW'(head_own)) ? rdata_b : 32'sd0;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_RET:   begin mul_x = old_v;   mul_y = old_v;   end
            S_P1:    begin mul_x = old_v;   mul_y = peer_v;  end
            S_P2:    begin mul_x = ret_reg; mul_y = ret_reg; end
            S_P3:    begin mul_x = ret_reg; mul_y = peer_v;  end
            S_MA:    begin mul_x = ma_reg;  mul_y = mb_reg;  end
            S_MB:    begin mul_x = mb_reg;  mul_y = mb_reg;  end
            default: begin mul_x = 32'sd0;  mul_y = 32'sd0;  end
        endcase
    end

    assign mul_p   = mul_x * mul_y;
    assign ldiff   = $signed({1'b0, log_p}) - $signed({1'b0, log_l});
    assign rnd     = 63'(lnp_reg) + 63'h80000000;
    assign sum_own = is_b ? sum_b_reg : sum_a_reg;
    assign sq_own  = is_b ? sq_b_reg : sq_a_reg;

    assign lane_val[0] = 64'(sum_a_reg);
    assign lane_val[1] = 64'(sum_b_reg);
    assign lane_val[2] = cross_reg;
    assign lane_val[3] = sq_b_reg;

    always_comb
    begin
        for (k = 0; k < 4; k++)
            lane_q[k] = lane_neg_reg[k] ? -$signed(lane_dq_reg[k]) : $signed(lane_dq_reg[k]);
    end

    assign cmag     = cov_reg[63] ? 64'(-cov_reg) : 64'(cov_reg);
    assign r_ge     = (r_reg >= d_reg);
    assign r_sub    = r_ge ? (r_reg - d_reg) : r_reg;
    assign dev      = $signed(34'(beta_reg)) - ONE_Q24;
    assign dev_mag  = dev[33] ? 34'(-dev) : 34'(dev);
    assign out_load = (state_reg == S_OUT) && (dev_mag > 34'(thr_reg))
                      && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= THRESH_RESET;
            minv_reg      <= MINVAR_RESET;
            kind_reg      <= KIND_OTHER;
            last_a_reg    <= 63'd0;
            last_b_reg    <= 63'd0;
            head_a_reg    <= '0;
            head_b_reg    <= '0;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            fill_reg      <= '0;
            sum_a_reg     <= 40'sd0;
            sum_b_reg     <= 40'sd0;
            sq_a_reg      <= 64'sd0;
            sq_b_reg      <= 64'sd0;
            cross_reg     <= 64'sd0;
            step_reg      <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_THRESH: thr_reg  <= cfg_data[30:0];
                    CFG_MINVAR: minv_reg <= cfg_data;
                    default:    ;
                endcase
            end

            mprod_reg <= mul_p;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        kind_reg  <= q_item.kind;
                        price_reg <= q_item.price;
                        time_reg  <= q_item.tick_time;
                        state_reg <= (q_item.kind == KIND_OTHER) ? S_EVAL : S_LOG;
                    end
                end
                S_LOG:
                begin
                    if (done_p && done_l)
                    begin
                        neg_reg   <= ldiff[34];
                        mag_reg   <= ldiff[34] ? 34'(-ldiff) : 34'(ldiff);
                        state_reg <= S_RMUL;
                    end
                end
                S_RMUL:
                begin
                    lnp_reg   <= 62'(mag_reg) * 62'(LN2_Q28);
                    state_reg <= S_RET;
                end
                S_RET:
                begin
                    if ((is_b ? last_b_reg : last_a_reg) == 63'd0)
                        ret_reg <= 32'sd0;
                    else if (price_reg == 63'd0)
                        ret_reg <= S32_MIN;
                    else if (neg_reg)
                        ret_reg <= -$signed({1'b0, rnd[62:32]});
                    else
                        ret_reg <= $signed({1'b0, rnd[62:32]});
                    if (is_b)
                        sum_b_reg <= clamp40({sum_own[39], sum_own} - 41'(old_v));
                    else
                        sum_a_reg <= clamp40({sum_own[39], sum_own} - 41'(old_v));
                    state_reg <= S_P1;
                end
                S_P1:
                begin
                    if (is_b)
                        sq_b_reg <= sat_sub64(sq_own, mprod_reg);
                    else
                        sq_a_reg <= sat_sub64(sq_own, mprod_reg);
                    state_reg <= S_P2;
                end
                S_P2:
                begin
                    cross_reg <= sat_sub64(cross_reg, mprod_reg);
                    if (is_b)
                        sum_b_reg <= clamp40({sum_own[39], sum_own} + 41'(ret_reg));
                    else
                        sum_a_reg <= clamp40({sum_own[39], sum_own} + 41'(ret_reg));
                    state_reg <= S_P3;
                end
                S_P3:
                begin
                    if (is_b)
                        sq_b_reg <= sat_add64(sq_own, mprod_reg);
                    else
                        sq_a_reg <= sat_add64(sq_own, mprod_reg);
                    state_reg <= S_P4;
                end
                S_P4:
                begin
                    cross_reg <= sat_add64(cross_reg, mprod_reg);
                    if (is_b)
                    begin
                        last_b_reg <= price_reg;
                        head_b_reg <= (head_b_reg == AW'(WINDOW_LEN - 1)) ? '0
                                                                         : head_b_reg + 1'b1;
                        if (cnt_b_reg != CW'(WINDOW_LEN))
                            cnt_b_reg <= cnt_b_reg + 1'b1;
                    end
                    else
                    begin
                        last_a_reg <= price_reg;
                        head_a_reg <= (head_a_reg == AW'(WINDOW_LEN - 1)) ? '0
                                                                         : head_a_reg + 1'b1;
                        if (cnt_a_reg != CW'(WINDOW_LEN))
                            cnt_a_reg <= cnt_a_reg + 1'b1;
                    end
                    if (fill_reg != CW'(WINDOW_LEN))
                        fill_reg <= fill_reg + 1'b1;
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (fill_reg != CW'(WINDOW_LEN))
                        state_reg <= S_IDLE;
                    else
                    begin
                        // divide by the window length on the magnitude: truncates toward zero
                        for (int j = 0; j < 4; j++)
                        begin
                            lane_neg_reg[j] <= lane_val[j][63];
                            lane_dq_reg[j]  <= (lane_val[j][63] ? 64'(-lane_val[j])
                                                                : 64'(lane_val[j])) >> AW;
                        end
                        state_reg <= S_MEAN;
                    end
                end
                S_MEAN:
                begin
                    ma_reg    <= clamp32(lane_q[0]);
                    mb_reg    <= clamp32(lane_q[1]);
                    state_reg <= S_MA;
                end
                S_MA:
                    state_reg <= S_MB;
                S_MB:
                begin
                    cov_reg   <= sat_sub64(lane_q[2], mprod_reg);
                    state_reg <= S_VAR;
                end
                S_VAR:
                begin
                    var_reg   <= sat_sub64(lane_q[3], mprod_reg);
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (var_reg <= 64'sd0 || var_reg < $signed({32'd0, minv_reg}))
                        state_reg <= S_IDLE;
                    else
                    begin
                        bsat_reg <= ({7'd0, cmag} >= {var_reg, 7'd0});
                        r_reg    <= 70'(cmag);
                        d_reg    <= {var_reg, 6'd0};
                        q_reg    <= 31'd0;
                        step_reg <= 6'd0;
                        state_reg <= ({7'd0, cmag} >= {var_reg, 7'd0}) ? S_DEC : S_BDIV;
                    end
                end
                S_BDIV:
                begin
                    // seven integer bits against a shifting divisor, then 24 fraction bits
                    q_reg <= {q_reg[29:0], r_ge};
                    if (step_reg < 6'd6)
                    begin
                        r_reg <= r_sub;
                        d_reg <= d_reg >> 1;
                    end
                    else
                        r_reg <= r_sub << 1;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd30)
                        state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    if (bsat_reg)
                        beta_reg <= cov_reg[63] ? S32_MIN : S32_MAX;
                    else
                        beta_reg <= cov_reg[63] ? -$signed({1'b0, q_reg})
                                                : $signed({1'b0, q_reg});
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (dev_mag <= 34'(thr_reg))
                        state_reg <= S_IDLE;
                    else if (out_load)
                    begin
                        out_time_reg  <= time_reg;
                        out_beta_reg  <= beta_reg;
                        out_dir_reg   <= (34'(beta_reg) > ONE_Q24);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_dir_reg, out_beta_reg, out_time_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW_LEN) && cnt_a_reg <= fill_reg && cnt_b_reg <= fill_reg)
        else $error("push counts out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_P4 |=> fill_reg == CW'(WINDOW_LEN) || fill_reg == $past(fill_reg) + 1'b1)
        else $error("fill count did not advance on push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> out_valid_reg && $stable(out_beta_reg))
        else $error("pending result lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE && q_valid)
        else $error("queue popped outside idle");

endmodule

### src/rolling_beta_signal.sv
// An A or B tick passes the log units and the ring and sum update; once the window is full,
// every tick then goes on to the means, covariance, variance and beta divider. The stages are
// the shared 35-step log units (normalize, then 28 squarings), the shift-based window means and
// the 31-step beta divider; one tick is worked at a time, a 2-entry queue takes more.
// A result holds in the output register until taken; a waiting result stalls the next signal.
// Reset clears sums, heads, push counts and prices; ring entries read as zero until written.
module rolling_beta_signal
    import rbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // price[62:0], tick_time[126:63], pad
    input  logic [1:0]   s_axis_tuser,   // symbol[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata    // signal_time[63:0], beta_value[95:64], direction[96]
);

    logic   q_valid;
    logic   q_pop;
    qitem_t q_item;

    rbs_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    rbs_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

endmodule

### verif/rbs_checker.sv
module rbs_checker
    import rbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // price[62:0], tick_time[126:63], pad
    input  logic [1:0]   s_axis_tuser,   // symbol[1:0]
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,   // signal_time[63:0], beta_value[95:64], direction[96]
    output int           pending,
    output int           errors
);

    localparam int    WIN    = WINDOW_LEN;
    localparam longint S40_HI = 64'sd549755813887;
    localparam longint S40_LO = -64'sd549755813888;
    localparam longint Q24_ONE = 64'sd16777216;
    localparam longint LN2_FIX = 64'sd186065279;

    typedef struct {
        logic signed [63:0] stamp;
        logic signed [31:0] beta;
        logic               buy;
    } signal_t;

    signal_t signal_q[$];

    logic [30:0] dev_limit;
    logic [31:0] var_floor;
    logic [62:0] prev_price[2];
    int          ring[2][WIN];
    int          head[2];
    int          pushes;
    longint      win_sum[2];
    longint      win_sq[2];
    longint      cross_sum;

    function automatic longint sadd(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
        return s[63:0];
    endfunction

    function automatic longint ssub(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
        return s[63:0];
    endfunction

    function automatic longint sat40(longint v);
        if (v > S40_HI)
            return S40_HI;
        if (v < S40_LO)
            return S40_LO;
        return v;
    endfunction

    // integer part = index of top bit, 28 fraction bits by repeated squaring
    function automatic longint log2_fix(logic [62:0] x);
        int         e;
        logic [63:0] y;
        logic [63:0] s;
        logic [63:0] frac;
        e = 62;
        while (e > 0 && x[e] == 1'b0)
            e--;
        y = ({1'b0, x} << (63 - e)) >> 32;
        frac = 0;
        for (int i = 0; i < 28; i++)
        begin
            s = y * y;
            frac = frac << 1;
            if (s[63])
            begin
                frac[0] = 1'b1;
                y = s >> 32;
            end
            else
                y = s >> 31;
        end
        return (longint'(e) << 28) | longint'(frac);
    endfunction

    function automatic int log_return(logic [62:0] p, logic [62:0] last);
        longint     d;
        logic [63:0] mag;
        logic [63:0] r;
        if (last == 0)
            return 0;
        if (p == 0)
            return 32'sh80000000;
        d = log2_fix(p) - log2_fix(last);
        mag = d < 0 ? -d : d;
        r = (mag * 64'(LN2_FIX) + 64'h80000000) >> 32;
        return d < 0 ? -int'(r) : int'(r);
    endfunction

    function automatic longint mean_of(longint s);
        longint m;
        m = s / WIN;
        if (m > 64'sd2147483647)
            m = 64'sd2147483647;
        if (m < -64'sd2147483648)
            m = -64'sd2147483648;
        return m;
    endfunction

    task automatic push_return(int k, int r);
        int     h;
        longint old;
        longint peer;
        h = head[k];
        old = ring[k][h];
        peer = ring[1 - k][h];
        win_sum[k] = sat40(win_sum[k] - old);
        win_sq[k] = ssub(win_sq[k], old * old);
        cross_sum = ssub(cross_sum, old * peer);
        ring[k][h] = r;
        win_sum[k] = sat40(win_sum[k] + longint'(r));
        win_sq[k] = sadd(win_sq[k], longint'(r) * longint'(r));
        cross_sum = sadd(cross_sum, longint'(r) * peer);
        head[k] = (h + 1) % WIN;
        if (pushes < WIN)
            pushes++;
    endtask

    task automatic predict_tick(logic [1:0] sym, logic [62:0] p, logic signed [63:0] stamp);
        longint      ma;
        longint      mb;
        longint      cov;
        longint      vr;
        longint      beta;
        longint      dev;
        logic [63:0] cmag;
        logic [63:0] vmag;
        logic [63:0] ip;
        logic [63:0] r;
        logic [63:0] q;
        signal_t     sig;
        if (sym == KIND_A || sym == KIND_B)
        begin
            push_return(int'(sym), log_return(p, prev_price[sym]));
            prev_price[sym] = p;
        end
        if (pushes < WIN)
            return;
        ma = mean_of(win_sum[0]);
        mb = mean_of(win_sum[1]);
        cov = ssub(cross_sum / WIN, ma * mb);
        vr = ssub(win_sq[1] / WIN, mb * mb);
        if (vr <= 0 || vr < longint'(var_floor))
            return;
        cmag = cov < 0 ? 64'd0 - 64'(cov) : 64'(cov);
        vmag = 64'(vr);
        ip = cmag / vmag;
        if (ip >= 128)
            beta = cov < 0 ? -64'sd2147483648 : 64'sd2147483647;
        else
        begin
            r = cmag % vmag;
            q = ip;
            for (int i = 0; i < 24; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= vmag)
                begin
                    r = r - vmag;
                    q[0] = 1'b1;
                end
            end
            beta = cov < 0 ? -longint'(q) : longint'(q);
        end
        dev = beta - Q24_ONE;
        if (dev < 0)
            dev = -dev;
        if (dev <= longint'(dev_limit))
            return;
        sig.stamp = stamp;
        sig.beta = beta[31:0];
        sig.buy = beta > Q24_ONE;
        signal_q.push_back(sig);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        signal_t want;
        if (!rst_n)
        begin
            dev_limit = THRESH_RESET;
            var_floor = MINVAR_RESET;
            prev_price[0] = 0;
            prev_price[1] = 0;
            head[0] = 0;
            head[1] = 0;
            pushes = 0;
            win_sum = '{0, 0};
            win_sq = '{0, 0};
            cross_sum = 0;
            for (int i = 0; i < WIN; i++)
            begin
                ring[0][i] = 0;
                ring[1][i] = 0;
            end
            signal_q.delete();
            pending <= 0;
            errors <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (signal_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected signal: time=%0d beta=%0d dir=%0b",
                                 $signed(m_axis_tdata[63:0]), $signed(m_axis_tdata[95:64]),
                                 m_axis_tdata[96]);
                    errors <= errors + 1;
                end
                else
                begin
                    want = signal_q.pop_front();
                    if (m_axis_tdata[63:0] !== want.stamp || m_axis_tdata[95:64] !== want.beta
                        || m_axis_tdata[96] !== want.buy)
                    begin
                        if (errors < 10)
                            $display("signal mismatch: exp time=%0d beta=%0d dir=%0b, got time=%0d beta=%0d dir=%0b",
                                     want.stamp, want.beta, want.buy,
                                     $signed(m_axis_tdata[63:0]), $signed(m_axis_tdata[95:64]),
                                     m_axis_tdata[96]);
                        errors <= errors + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_THRESH)
                    dev_limit = cfg_data[30:0];
                else
                    var_floor = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_tick(s_axis_tuser, s_axis_tdata[62:0], s_axis_tdata[126:63]);
            pending <= signal_q.size();
        end
    end

endmodule

### verif/tb.sv
module tb
    import rbs_pkg::*;
();

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic         cfg_index;
    logic [31:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // price[62:0], tick_time[126:63], pad
    logic [1:0]   s_axis_tuser;   // symbol[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;   // signal_time[63:0], beta_value[95:64], direction[96]
    int           pending;
    int           errors;
    int           idle_pct;
    int           stall_pct;
    logic [62:0]  walk_price[2];

    localparam logic [62:0] PRICE_MAX = {63{1'b1}};

    rolling_beta_signal DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    rbs_checker beta_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .pending(pending), .errors(errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    task automatic send_tick(logic [1:0] sym, logic [62:0] p, logic signed [63:0] stamp);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= sym;
        s_axis_tdata <= {1'b0, stamp, p};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // wait out in-flight ticks that produce no signal before touching config
    task automatic drain_then_config(logic [31:0] thresh, logic [31:0] floor);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_THRESH;
        cfg_data <= thresh;
        @(posedge clk);
        cfg_index <= CFG_MINVAR;
        cfg_data <= floor;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_tick();
        int          k;
        int          pick;
        logic [62:0] base;
        logic [62:0] step;
        logic signed [63:0] stamp;
        stamp = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 88)
        begin
            // random walk on a valid price, small moves
            k = $urandom_range(0, 1);
            base = walk_price[k];
            if (base == 0 || base > 63'd1000000000000000)
                base = 63'($urandom_range(1, 100000)) * 63'd100000000;
            step = (base / 1000) * $urandom_range(0, 30);
            walk_price[k] = $urandom_range(0, 1) ? base + step : base - step;
            if (walk_price[k] == 0)
                walk_price[k] = 1;
            send_tick(kind_t'(k), walk_price[k], stamp);
        end
        else if (pick < 93)
            send_tick(2'($urandom_range(2, 3)), 63'({$urandom, $urandom}), stamp);
        else if (pick < 96)
            send_tick(2'($urandom_range(0, 1)), 63'd0, stamp);
        else if (pick < 98)
            send_tick(2'($urandom_range(0, 1)), PRICE_MAX - 63'($urandom_range(0, 3)), stamp);
        else
            send_tick(2'($urandom_range(0, 1)), 63'({$urandom, $urandom}), stamp);
    endtask

    initial
    begin
        int idle_tab[5];
        int stall_tab[5];
        logic [31:0] th_tab[5];
        logic [31:0] mv_tab[5];
        idle_tab = '{0, 79, 0, 31, 0};
        stall_tab = '{0, 0, 79, 31, 0};
        th_tab = '{32'd838861, 32'd0, 32'h7fffffff, 32'd100000, 32'hffffffff};
        mv_tab = '{32'd281, 32'd0, 32'hffffffff, 32'd5000000, 32'd1};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_THRESH;
        cfg_data = 32'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_A;
        m_axis_tready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        walk_price = '{63'd0, 63'd0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first tick of each asset, zero price and recovery, extremes, other symbols
        send_tick(KIND_A, 63'd5000000000, 64'sh8000000000000000);
        send_tick(KIND_B, 63'd7000000000, 64'sh7fffffffffffffff);
        send_tick(KIND_A, 63'd5100000000, 64'sd0);
        send_tick(KIND_B, 63'd6900000000, -64'sd1);
        send_tick(KIND_OTHER, PRICE_MAX, 64'sd1);
        send_tick(2'd3, 63'd0, 64'sh5555555555555555);
        send_tick(KIND_A, 63'd0, 64'shaaaaaaaaaaaaaaa);
        send_tick(KIND_A, 63'd1, 64'sd2);
        send_tick(KIND_A, PRICE_MAX, 64'sd3);
        send_tick(KIND_A, 63'd1, 64'sd4);
        send_tick(KIND_B, 63'd0, 64'sd5);
        send_tick(KIND_B, PRICE_MAX, 64'sd6);
        send_tick(KIND_B, 63'd1, 64'sd7);
        send_tick(KIND_B, 63'h2aaaaaaaaaaaaaaa, 64'sd8);
        send_tick(KIND_A, 63'h5555555555555555, 64'sd9);
        send_tick(KIND_OTHER, 63'd0, 64'sd10);

        for (int ph = 0; ph < 5; ph++)
        begin
            drain_then_config(th_tab[ph], mv_tab[ph]);
            idle_pct = idle_tab[ph];
            stall_pct = stall_tab[ph];
            for (int n = 0; n < 350; n++)
                random_tick();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
src/rbs_pkg.sv
src/rbs_ram.sv
src/rbs_front.sv
src/rbs_log.sv
src/rbs_back.sv
src/rolling_beta_signal.sv
verif/rbs_checker.sv
verif/tb.sv
